// ===== design/fste_pkg.sv =====
// Shared types and constants for the format string text engine.
// No dependencies; every other file in the block depends on this package.
package fste_pkg;

   localparam int CHAR_W  = 8;
   localparam int KIND_W  = 2;
   localparam int COUNT_W = 31;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CH_PCT   = 8'h25;
   localparam logic [CHAR_W-1:0] CH_C     = 8'h63;
   localparam logic [CHAR_W-1:0] CH_S     = 8'h73;
   localparam logic [CHAR_W-1:0] CH_I     = 8'h69;
   localparam logic [CHAR_W-1:0] CH_D     = 8'h64;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

   // double dabble digit correction
   localparam logic [3:0] BCD_ADJ_LIMIT = 4'd5;
   localparam logic [3:0] BCD_ADJ       = 4'd3;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_CHAR    = 2'd0,
      KIND_DONE    = 2'd1,
      KIND_BAD_PCT = 2'd2,
      KIND_SEQ     = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      MODE_PLAIN,
      MODE_PCT,
      MODE_STR
   } mode_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_CHAR,
      OP_PCT_CHAR,
      OP_DEC,
      OP_DONE,
      OP_BAD_PCT,
      OP_SEQ
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [CHAR_W-1:0]   ch;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_PCT2,
      BK_CONV,
      BK_SIGN,
      BK_DIGIT
   } back_state_type;

endpackage

// ===== design/fste_channels.sv =====
// Request and response channel interfaces (valid/ready plus payload).
// Depends on fste_pkg for field widths.
interface fste_req_if #(parameter int ARG_BITS = 32);
   logic                                valid;
   logic                                ready;
   logic                                func;
   logic [fste_pkg::CHAR_W-1:0]         ch;
   logic signed [ARG_BITS-1:0]          arg_value;

   modport source (output valid, func, ch, arg_value, input ready);
   modport sink   (input valid, func, ch, arg_value, output ready);
endinterface

interface fste_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [fste_pkg::KIND_W-1:0]         out_kind;
   logic [fste_pkg::CHAR_W-1:0]         out_char;
   logic [fste_pkg::COUNT_W-1:0]        out_count;
   logic                                last;

   modport source (output valid, out_kind, out_char, out_count, last, input ready);
   modport sink   (input valid, out_kind, out_char, out_count, last, output ready);
endinterface

// ===== design/format_string_text_engine.sv =====
// Format string text engine top: parser front, two-entry command queue, emitter back.
// Text, %c, %% and status: the item is queued and the back registers the response,
// then one per cycle while rsp.ready holds. %d/%i: a pop, ARG_BITS shift-add-3 steps,
// then leading zeros are skipped and the sign and digits are emitted in order.
// Synchronous active-high reset clears the format mode, the queue, the emitted count
// and the response valid. Depends on fste_pkg, fste_channels, fste_queue/front/back.
module format_string_text_engine #(
   parameter int ARG_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   fste_req_if.sink   req,
   fste_rsp_if.source rsp
);
   import fste_pkg::*;

   localparam int Q_W = $bits(cmd_type) + ARG_BITS + 1;

   q_status_type        status;
   logic                push;
   logic                pop;
   cmd_type             push_cmd;
   cmd_type             q_cmd;
   logic [ARG_BITS-1:0] push_mag;
   logic [ARG_BITS-1:0] q_mag;
   logic                push_neg;
   logic                q_neg;
   logic [Q_W-1:0]      q_data;

   fste_front #(.ARG_BITS(ARG_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .status   (status),
      .push     (push),
      .push_cmd (push_cmd),
      .push_mag (push_mag),
      .push_neg (push_neg)
   );

   fste_queue #(.WIDTH(Q_W)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_cmd, push_mag, push_neg}),
      .pop       (pop),
      .pop_data  (q_data),
      .status    (status)
   );

   assign {q_cmd, q_mag, q_neg} = q_data;

   fste_back #(.ARG_BITS(ARG_BITS)) u_back (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .q_cmd  (q_cmd),
      .q_mag  (q_mag),
      .q_neg  (q_neg),
      .pop    (pop),
      .rsp    (rsp)
   );

endmodule

// ===== design/fste_queue.sv =====
// Two-entry command queue between the parser front and the emitter back.
// Depends on fste_pkg.
module fste_queue #(
   parameter int WIDTH = 48
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output fste_pkg::q_status_type     status
);
   import fste_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] mem [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data     = mem[rd_ptr_ff];
   assign status.full  = (fill_ff == CNT_W'(QUEUE_DEPTH));
   assign status.empty = (fill_ff == '0);

endmodule

// ===== design/fste_front.sv =====
// Parser front: accepts request items, tracks the format mode and
// classifies each item into a command for the back. Depends on fste_pkg.
module fste_front #(
   parameter int ARG_BITS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   fste_req_if.sink                   req,
   input  fste_pkg::q_status_type     status,
   output logic                       push,
   output fste_pkg::cmd_type          push_cmd,
   output logic [ARG_BITS-1:0]        push_mag,
   output logic                       push_neg
);
   import fste_pkg::*;

   mode_type            mode_ff, mode_in;
   logic                accept;
   logic [ARG_BITS-1:0] raw;

   assign req.ready = !status.full;
   assign accept    = req.valid && req.ready;
   assign raw       = req.arg_value;
   assign push_neg  = raw[ARG_BITS-1];
   assign push_mag  = push_neg ? (~raw) + {{(ARG_BITS-1){1'b0}}, 1'b1} : raw;

   always_comb begin
      mode_in     = mode_ff;
      push_cmd.op = OP_NONE;
      push_cmd.ch = req.ch;
      if (accept) begin
         if (req.func) begin
            if (mode_ff != MODE_STR) begin
               push_cmd.op = OP_SEQ;
            end else if (req.ch == CH_NUL) begin
               mode_in = MODE_PLAIN;
            end else begin
               push_cmd.op = OP_CHAR;
            end
         end else begin
            case (mode_ff)
               MODE_PLAIN: begin
                  if (req.ch == CH_NUL) begin
                     push_cmd.op = OP_DONE;
                  end else if (req.ch == CH_PCT) begin
                     mode_in = MODE_PCT;
                  end else begin
                     push_cmd.op = OP_CHAR;
                  end
               end
               MODE_PCT: begin
                  mode_in = MODE_PLAIN;
                  case (req.ch)
                     CH_NUL: push_cmd.op = OP_BAD_PCT;
                     CH_C: begin
                        push_cmd.op = OP_CHAR;
                        push_cmd.ch = raw[CHAR_W-1:0];
                     end
                     CH_D, CH_I: push_cmd.op = OP_DEC;
                     CH_S: mode_in = MODE_STR;
                     CH_PCT: push_cmd.op = OP_CHAR;
                     default: push_cmd.op = OP_PCT_CHAR;
                  endcase
               end
               default: push_cmd.op = OP_SEQ;
            endcase
         end
      end
   end

   assign push = accept && (push_cmd.op != OP_NONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_PLAIN;
      end else begin
         mode_ff <= mode_in;
      end
   end

endmodule

// ===== design/fste_back.sv =====
// Emitter back: pops commands, runs the shift-add-3 decimal conversion and
// drives the registered response channel. Owns the emitted count. Depends on fste_pkg.
module fste_back #(
   parameter int ARG_BITS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  fste_pkg::q_status_type     status,
   input  fste_pkg::cmd_type          q_cmd,
   input  logic [ARG_BITS-1:0]        q_mag,
   input  logic                       q_neg,
   output logic                       pop,
   fste_rsp_if.source                 rsp
);
   import fste_pkg::*;

   localparam int DIG_MAX = (ARG_BITS * 77) / 256 + 1;
   localparam int BCD_W   = DIG_MAX * 4;
   localparam int DIG_W   = $clog2(DIG_MAX + 1);
   localparam int STEP_W  = $clog2(ARG_BITS + 1);

   back_state_type       state_ff, state_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [ARG_BITS-1:0]  bin_ff, bin_in;
   logic [BCD_W-1:0]     bcd_ff, bcd_in, bcd_adj;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [DIG_W-1:0]     dig_ff, dig_in;
   logic                 seen_ff, seen_in;
   logic                 neg_ff, neg_in;
   logic [CHAR_W-1:0]    ch_ff, ch_in;

   logic                 valid_ff, valid_in;
   kind_type             kind_ff, kind_in;
   logic [CHAR_W-1:0]    char_ff, char_in;
   logic [COUNT_W-1:0]   cnt_ff, cnt_in;
   logic                 last_ff, last_in;

   logic                 out_free;
   logic                 emit;
   kind_type             e_kind;
   logic [CHAR_W-1:0]    e_char;
   logic [COUNT_W-1:0]   e_count;
   logic                 e_last;
   logic [3:0]           top_digit;

   assign out_free  = !valid_ff || rsp.ready;
   assign top_digit = bcd_ff[BCD_W-1 -: 4];

   always_comb begin
      for (int i = 0; i < DIG_MAX; i++) begin
         bcd_adj[i*4 +: 4] = (bcd_ff[i*4 +: 4] >= BCD_ADJ_LIMIT) ?
                             bcd_ff[i*4 +: 4] + BCD_ADJ : bcd_ff[i*4 +: 4];
      end
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      step_in  = step_ff;
      dig_in   = dig_ff;
      seen_in  = seen_ff;
      neg_in   = neg_ff;
      ch_in    = ch_ff;
      valid_in = out_free ? 1'b0 : valid_ff;
      kind_in  = kind_ff;
      char_in  = char_ff;
      cnt_in   = cnt_ff;
      last_in  = last_ff;
      pop      = 1'b0;
      emit     = 1'b0;
      e_kind   = KIND_CHAR;
      e_char   = '0;
      e_count  = '0;
      e_last   = 1'b1;

      case (state_ff)
         BK_IDLE: begin
            if (!status.empty) begin
               case (q_cmd.op)
                  OP_DEC: begin
                     pop      = 1'b1;
                     bin_in   = q_mag;
                     neg_in   = q_neg;
                     bcd_in   = '0;
                     step_in  = STEP_W'(ARG_BITS);
                     state_in = BK_CONV;
                  end
                  OP_CHAR: begin
                     if (out_free) begin
                        pop    = 1'b1;
                        emit   = 1'b1;
                        e_char = q_cmd.ch;
                     end
                  end
                  OP_PCT_CHAR: begin
                     if (out_free) begin
                        pop      = 1'b1;
                        emit     = 1'b1;
                        e_char   = CH_PCT;
                        e_last   = 1'b0;
                        ch_in    = q_cmd.ch;
                        state_in = BK_PCT2;
                     end
                  end
                  OP_DONE: begin
                     if (out_free) begin
                        pop      = 1'b1;
                        emit     = 1'b1;
                        e_kind   = KIND_DONE;
                        e_count  = count_ff;
                        count_in = '0;
                     end
                  end
                  OP_BAD_PCT: begin
                     if (out_free) begin
                        pop      = 1'b1;
                        emit     = 1'b1;
                        e_kind   = KIND_BAD_PCT;
                        count_in = '0;
                     end
                  end
                  OP_SEQ: begin
                     if (out_free) begin
                        pop    = 1'b1;
                        emit   = 1'b1;
                        e_kind = KIND_SEQ;
                     end
                  end
                  default: pop = 1'b1;
               endcase
            end
         end
         BK_PCT2: begin
            if (out_free) begin
               emit     = 1'b1;
               e_char   = ch_ff;
               state_in = BK_IDLE;
            end
         end
         BK_CONV: begin
            {bcd_in, bin_in} = {bcd_adj[BCD_W-2:0], bin_ff, 1'b0};
            step_in = step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               dig_in   = DIG_W'(DIG_MAX);
               seen_in  = 1'b0;
               state_in = neg_ff ? BK_SIGN : BK_DIGIT;
            end
         end
         BK_SIGN: begin
            if (out_free) begin
               emit     = 1'b1;
               e_char   = CH_MINUS;
               e_last   = 1'b0;
               state_in = BK_DIGIT;
            end
         end
         BK_DIGIT: begin
            if (!seen_ff && top_digit == 4'd0 && dig_ff != DIG_W'(1)) begin
               bcd_in = {bcd_ff[BCD_W-5:0], 4'd0};
               dig_in = dig_ff - 1'b1;
            end else if (out_free) begin
               emit    = 1'b1;
               e_char  = CH_ZERO + {4'd0, top_digit};
               e_last  = (dig_ff == DIG_W'(1));
               bcd_in  = {bcd_ff[BCD_W-5:0], 4'd0};
               dig_in  = dig_ff - 1'b1;
               seen_in = 1'b1;
               if (dig_ff == DIG_W'(1)) begin
                  state_in = BK_IDLE;
               end
            end
         end
         default: state_in = BK_IDLE;
      endcase

      if (emit) begin
         valid_in = 1'b1;
         kind_in  = e_kind;
         char_in  = e_char;
         cnt_in   = e_count;
         last_in  = e_last;
         if (e_kind == KIND_CHAR && count_ff != COUNT_MAX) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff  <= bin_in;
      bcd_ff  <= bcd_in;
      step_ff <= step_in;
      dig_ff  <= dig_in;
      seen_ff <= seen_in;
      neg_ff  <= neg_in;
      ch_ff   <= ch_in;
      kind_ff <= kind_in;
      char_ff <= char_in;
      cnt_ff  <= cnt_in;
      last_ff <= last_in;
   end

   assign rsp.valid     = valid_ff;
   assign rsp.out_kind  = kind_ff;
   assign rsp.out_char  = char_ff;
   assign rsp.out_count = cnt_ff;
   assign rsp.last      = last_ff;

endmodule
